// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rfr modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfr_pkg.sv =====
// types and constants of the radio frame receiver
package rfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned VALUE_BYTES = VALUE_W / BYTE_W;
    localparam int unsigned VB_IDX_W    = $clog2(VALUE_BYTES);
    localparam int unsigned HDR_BYTES   = 5;
    localparam int unsigned CFG_IDX_W   = 2;

    // byte positions after the first start byte
    localparam logic [POS_W-1:0] POS_START2 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SOURCE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DEST   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_OBJECT = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(4);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_CHECK_ERR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE   = 2'd0,
        CFG_OWN_ID       = 2'd1,
        CFG_ACK_CODE     = 2'd2,
        CFG_REQUEST_CODE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] own_id;
        logic [BYTE_W-1:0] ack_code;
        logic [BYTE_W-1:0] request_code;
    } rfr_cfg_t;

    typedef struct packed {
        logic               frame_status;
        logic [BYTE_W-1:0]  source_id;
        logic [BYTE_W-1:0]  object_code;
        logic [LEN_W-1:0]   payload_length;
        logic [VALUE_W-1:0] payload_value;
        logic               ack_due;
    } rfr_result_t;

endpackage

// ===== rtl/rfr_if.sv =====
// channel interfaces: received bytes, frame results, register writes

interface rfr_byte_if import rfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfr_result_if import rfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               frame_status;
    logic [BYTE_W-1:0]  source_id;
    logic [BYTE_W-1:0]  object_code;
    logic [LEN_W-1:0]   payload_length;
    logic [VALUE_W-1:0] payload_value;
    logic               ack_due;

    modport source (output valid, output frame_status, output source_id,
                    output object_code, output payload_length,
                    output payload_value, output ack_due, input ready);
    modport sink   (input valid, input frame_status, input source_id,
                    input object_code, input payload_length,
                    input payload_value, input ack_due, output ready);
endinterface

interface rfr_cfg_if import rfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rfr_deframer.sv =====
// frame state and per-byte deframing logic
`include "assert_macros.svh"

module rfr_deframer
    import rfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_data,
    input  rfr_cfg_t          cfg,
    output logic              emit,
    output rfr_result_t       result
);

    logic               busy_reg, busy_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]  src_reg, src_next;
    logic [BYTE_W-1:0]  obj_reg, obj_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]  chk_reg, chk_next;
    logic [BYTE_W-1:0]  or_reg, or_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;

    logic [POS_W:0]     pos_ext;
    logic [POS_W:0]     body_end;
    logic [POS_W-1:0]   offset;
    logic               check_ok;

    assign pos_ext  = {1'b0, pos_reg};
    assign body_end = (POS_W+1)'(HDR_BYTES) + {1'b0, len_reg};
    assign offset   = pos_reg - POS_W'(HDR_BYTES);

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        src_next  = src_reg;
        obj_next  = obj_reg;
        len_next  = len_reg;
        chk_next  = chk_reg;
        or_next   = or_reg;
        acc_next  = acc_reg;
        emit      = 1'b0;
        if (!busy_reg)
        begin
            // hunting for the first start byte
            if (rx_data == cfg.start_byte)
            begin
                busy_next = 1'b1;
                pos_next  = '0;
                or_next   = '0;
                acc_next  = '0;
            end
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            case (pos_reg)
                POS_START2:
                begin
                    if (rx_data != cfg.start_byte)
                    begin
                        busy_next = 1'b0;
                        pos_next  = '0;
                    end
                end
                POS_SOURCE:
                begin
                    src_next = rx_data;
                end
                POS_DEST:
                begin
                    if (rx_data != cfg.own_id)
                    begin
                        busy_next = 1'b0;
                        pos_next  = '0;
                    end
                end
                POS_OBJECT:
                begin
                    obj_next = rx_data;
                    or_next  = rx_data;
                end
                POS_LENGTH:
                begin
                    if (rx_data > BYTE_W'(MAX_PAYLOAD))
                    begin
                        busy_next = 1'b0;
                        pos_next  = '0;
                    end
                    else
                    begin
                        len_next = rx_data[LEN_W-1:0];
                    end
                end
                default:
                begin
                    if (pos_ext < body_end)
                    begin
                        // payload byte: always into the check, first eight into the value
                        or_next = or_reg | rx_data;
                        if (offset < POS_W'(VALUE_BYTES))
                        begin
                            acc_next[BYTE_W*offset[VB_IDX_W-1:0] +: BYTE_W] =
                                acc_reg[BYTE_W*offset[VB_IDX_W-1:0] +: BYTE_W] | rx_data;
                        end
                    end
                    else if (pos_ext == body_end)
                    begin
                        chk_next = rx_data;
                    end
                    else
                    begin
                        // closing byte, value ignored
                        emit      = 1'b1;
                        busy_next = 1'b0;
                        pos_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (step)
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            src_reg <= src_next;
            obj_reg <= obj_next;
            len_reg <= len_next;
            chk_reg <= chk_next;
            or_reg  <= or_next;
            acc_reg <= acc_next;
        end
    end

    assign check_ok              = (chk_reg == or_reg);
    assign result.frame_status   = check_ok ? STATUS_OK : STATUS_CHECK_ERR;
    assign result.source_id      = src_reg;
    assign result.object_code    = obj_reg;
    assign result.payload_length = len_reg;
    assign result.payload_value  = acc_reg;
    assign result.ack_due        = check_ok && (obj_reg != cfg.ack_code)
                                   && (obj_reg != cfg.request_code);

    `RFR_ASSERT_IMPL(a_emit_needs_frame, emit, busy_reg, "result raised outside a frame")
    `RFR_ASSERT_NEXT(a_close_goes_idle, step && emit, !busy_reg, "frame still open after close")
    `RFR_ASSERT_IMPL(a_pos_bounded, busy_reg && (pos_reg > POS_LENGTH),
                     pos_ext <= body_end + 1'b1, "byte position ran past the closing byte")

endmodule

// ===== rtl/radio_frame_receiver.sv =====
// top level of the radio frame receiver: input stage, registers, result stage
//
//  channel  modport  payload                                   direction
//  rx       sink     rx_byte                                   bytes in
//  result   source   frame_status, source_id, object_code,     one item per frame
//                    payload_length, payload_value, ack_due
//  cfg      sink     index, data                               register writes
//
// one byte per cycle unless a closing byte waits on a held result: an input register
// feeds the deframing logic, which updates frame state and loads the result register
// a result is presented once its closing byte advances out of the input register
// rst_n is asynchronous and clears frame busy and position, stage valids and registers
// a held result stalls only a closing byte; other bytes keep flowing
// register writes are always taken, one per cycle
`include "assert_macros.svh"

module radio_frame_receiver
    import rfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 9
)
(
    input  logic   clk,
    input  logic   rst_n,
    rfr_byte_if.sink     rx,
    rfr_result_if.source result,
    rfr_cfg_if.sink      cfg
);

    rfr_cfg_t          cfg_reg;

    // input stage
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_data_reg;

    // result stage
    logic              out_valid_reg, out_valid_next;
    rfr_result_t       out_reg;

    logic              emit;
    rfr_result_t       frame_result;
    logic              out_free;
    logic              advance;
    logic              rx_take;

    // byte in the input stage moves on unless it closes a frame and the
    // result register is still occupied
    assign out_free = !out_valid_reg || result.ready;
    assign advance  = s1_valid_reg && (!emit || out_free);
    assign rx.ready = !s1_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    assign s1_valid_next  = rx_take || (s1_valid_reg && !advance);
    assign out_valid_next = (advance && emit) || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            s1_data_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            out_reg <= frame_result;
        end
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_START_BYTE:   cfg_reg.start_byte   <= cfg.data;
                CFG_OWN_ID:       cfg_reg.own_id       <= cfg.data;
                CFG_ACK_CODE:     cfg_reg.ack_code     <= cfg.data;
                CFG_REQUEST_CODE: cfg_reg.request_code <= cfg.data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // frame state and per-byte decisions
    rfr_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_data (s1_data_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (frame_result)
    );

    assign result.valid          = out_valid_reg;
    assign result.frame_status   = out_reg.frame_status;
    assign result.source_id      = out_reg.source_id;
    assign result.object_code    = out_reg.object_code;
    assign result.payload_length = out_reg.payload_length;
    assign result.payload_value  = out_reg.payload_value;
    assign result.ack_due        = out_reg.ack_due;

    `RFR_ASSERT_NEXT(a_result_loaded, advance && emit, out_valid_reg, "closing byte left no result")
    `RFR_ASSERT_IMPL(a_stall_only_on_close, s1_valid_reg && !advance,
                     emit && out_valid_reg && !result.ready, "input stage stalled without cause")
    `RFR_ASSERT_IMPL(a_ready_when_empty, !s1_valid_reg, rx.ready, "empty input stage refused a byte")

endmodule
